### sv/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

    localparam int SLOTS = 1024;
    localparam int GEN_W = 32;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = IDX_W + 1;

    // operation codes; code three behaves as a query
    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_ALIVE = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [9:0]  slot_index;
        logic [31:0] slot_generation;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  handle_index;
        logic [31:0] handle_generation;
        logic        alive;
        logic [10:0] live_total;
        logic [10:0] slots_touched;
    } t_rsp;

    typedef struct packed {
        logic             alive;
        logic [GEN_W-1:0] gen;
    } t_slot_entry;

endpackage

### sv/generational_handle_allocator_core.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_core
// Handle allocator with per-slot generation counters and a LIFO free stack.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction (create, destroy or query) is taken at a rising
//   edge with start high and busy low; i_req carries the operation, slot
//   index and generation. Exactly one result transaction follows: o_done is
//   high for one cycle with o_rsp valid. The receiver cannot stall; the
//   result must be captured in that cycle.
// Sequencer states visited after the accepting edge, before o_done is raised:
//   S_ISSUE           create of a never-used slot, create when full, or
//                     destroy/query of an index at or above the high-water mark
//   S_ISSUE, S_CHECK  destroy or query of a used slot (slot memory read)
//   S_ISSUE, S_POP, S_CHECK  create from the free stack (stack read, then slot read)
//   A new request may be accepted in the cycle o_done is high. The slot and
//   stack memories have registered read ports, and each is read at most once
//   per transaction.
// Reset (synchronous, active low) clears the counters and the sequencer.
//   Memories are not swept: slots at or above the high-water mark are treated
//   as dead and a first create writes generation zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module generational_handle_allocator_core
    import gha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,   // decide path, issue first memory read
        S_POP,     // stack data back, read slot entry
        S_CHECK    // slot entry back, respond; write back on create or matching destroy
    } t_state;

    t_state      r_state, n_state;
    t_req        r_req;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0] r_depth, n_depth;
    logic [CNT_W-1:0] r_hw, n_hw;
    logic [CNT_W-1:0] r_live, n_live;
    logic        r_done, n_done;
    t_rsp        r_rsp, n_rsp;

    // slot memory: alive bit and generation per slot
    t_slot_entry mem_slot [SLOTS];
    t_slot_entry slot_q;
    logic             slot_rd_en, slot_we;
    logic [IDX_W-1:0] slot_rd_addr, slot_wr_addr;
    t_slot_entry      slot_wr_data;

    // free stack memory
    logic [IDX_W-1:0] mem_stack [SLOTS];
    logic [IDX_W-1:0] stack_q;
    logic             stack_rd_en, stack_we;
    logic [IDX_W-1:0] stack_rd_addr, stack_wr_addr;

    logic [CNT_W-1:0] depth_m1;
    logic             handle_match;

    assign depth_m1     = r_depth - CNT_W'(1);
    assign handle_match = slot_q.alive && (slot_q.gen == r_req.slot_generation);

    always_comb begin
        n_state       = r_state;
        n_slot        = r_slot;
        n_depth       = r_depth;
        n_hw          = r_hw;
        n_live        = r_live;
        n_done        = 1'b0;
        n_rsp         = r_rsp;
        slot_rd_en    = 1'b0;
        slot_rd_addr  = r_req.slot_index;
        slot_we       = 1'b0;
        slot_wr_addr  = r_slot;
        slot_wr_data  = slot_q;
        stack_rd_en   = 1'b0;
        stack_rd_addr = depth_m1[IDX_W-1:0];
        stack_we      = 1'b0;
        stack_wr_addr = r_depth[IDX_W-1:0];

        // default result echoes the request
        n_rsp.status            = ST_OK;
        n_rsp.handle_index      = r_req.slot_index;
        n_rsp.handle_generation = r_req.slot_generation;
        n_rsp.alive             = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (r_req.operation == OP_CREATE) begin
                    if (r_depth != '0) begin
                        stack_rd_en = 1'b1;
                        n_depth     = depth_m1;
                        n_state     = S_POP;
                    end else if (r_hw < CNT_W'(SLOTS)) begin
                        // never-used slot: generation is still zero
                        slot_we                 = 1'b1;
                        slot_wr_addr            = r_hw[IDX_W-1:0];
                        slot_wr_data.alive      = 1'b1;
                        slot_wr_data.gen        = '0;
                        n_hw                    = r_hw + CNT_W'(1);
                        n_live                  = r_live + CNT_W'(1);
                        n_rsp.handle_index      = r_hw[IDX_W-1:0];
                        n_rsp.handle_generation = '0;
                        n_done                  = 1'b1;
                        n_state                 = S_IDLE;
                    end else begin
                        n_rsp.status = ST_FULL;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (CNT_W'(r_req.slot_index) >= r_hw) begin
                    n_rsp.status = ST_NOT_ALIVE;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    slot_rd_en = 1'b1;
                    n_slot     = r_req.slot_index;
                    n_state    = S_CHECK;
                end
            end
            S_POP: begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = stack_q;
                n_slot       = stack_q;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                case (r_req.operation)
                    OP_CREATE: begin
                        slot_we                 = 1'b1;
                        slot_wr_data.alive      = 1'b1;
                        n_live                  = r_live + CNT_W'(1);
                        n_rsp.handle_index      = r_slot;
                        n_rsp.handle_generation = slot_q.gen;
                    end
                    OP_DESTROY: begin
                        if (handle_match) begin
                            slot_we            = 1'b1;
                            slot_wr_data.alive = 1'b0;
                            slot_wr_data.gen   = slot_q.gen + GEN_W'(1);
                            if (r_depth < CNT_W'(SLOTS)) begin
                                stack_we = 1'b1;
                                n_depth  = r_depth + CNT_W'(1);
                            end
                            if (r_live != '0) begin
                                n_live = r_live - CNT_W'(1);
                            end
                            n_rsp.alive = 1'b1;
                        end else begin
                            n_rsp.status = ST_NOT_ALIVE;
                        end
                    end
                    default: begin
                        // query, and the unused code three
                        if (handle_match) begin
                            n_rsp.alive = 1'b1;
                        end else begin
                            n_rsp.status = ST_NOT_ALIVE;
                        end
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rsp.live_total    = n_live;
        n_rsp.slots_touched = n_hw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_hw    <= '0;
            r_live  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_hw    <= n_hw;
            r_live  <= n_live;
            r_done  <= n_done;
        end
        r_slot <= n_slot;
        if (n_done) begin
            r_rsp <= n_rsp;
        end
        if (r_state == S_IDLE && start) begin
            r_req <= i_req;
        end
    end

    // slot memory port
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            mem_slot[slot_wr_addr] <= slot_wr_data;
        end
        if (slot_rd_en) begin
            slot_q <= mem_slot[slot_rd_addr];
        end
    end

    // free stack port
    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            mem_stack[stack_wr_addr] <= r_slot;
        end
        if (stack_rd_en) begin
            stack_q <= mem_stack[stack_rd_addr];
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // every used slot is either live or on the free stack between transactions
    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_depth + r_live) == r_hw))
        else $error("free depth plus live count differs from high-water mark");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_alive_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.alive) |-> (o_rsp.status == ST_OK))
        else $error("live handle reported with an error status");

    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= CNT_W'(SLOTS))
        else $error("high-water mark beyond slot count");

    a_mem_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(slot_we && slot_rd_en))
        else $error("slot memory read and written in one cycle");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for generational_handle_allocator_core. Request
// transactions (create, destroy, query) are queued by a stimulus process and
// driven on the falling edge in random bursts. Every accepted request is run
// through a local allocator model that predicts the single result
// transaction. The monitor compares each strobed result, field by field,
// against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import gha_pkg::*;

    // code three is not decoded by the block and behaves as a query
    localparam logic [1:0] OP_SPARE = 2'd3;
    // cycles with neither a request nor a result accepted before giving up
    localparam int WATCHDOG_LIMIT = 500;
    localparam int PRINT_LIMIT = 50;

    typedef struct {
        t_req req;
        bit   hold;    // wait for every outstanding result before sending
    } t_stim;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_done;
    t_rsp o_rsp;

    generational_handle_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Allocator model: per-slot generation and alive bit, LIFO free stack,
    // high-water mark and live count. Updated once per accepted request.
    // ------------------------------------------------------------------------
    logic [GEN_W-1:0] gen_mem [SLOTS];
    logic             live_bit [SLOTS];
    logic [IDX_W-1:0] free_slots [$];
    logic [CNT_W-1:0] hw_mark;
    logic [CNT_W-1:0] live_cnt;

    t_stim pending [$];        // requests not yet driven
    t_rsp  expected_rsp [$];   // predicted results, oldest first

    int  n_errors = 0;
    int  idle_cycles = 0;
    logic req_taken = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    t_stim drive_item;

    function automatic t_rsp predict_step(input t_req r);
        t_rsp             rsp;
        logic [IDX_W-1:0] slot;
        logic             got;
        logic             hit;
        hit = (r.slot_index < hw_mark) && live_bit[r.slot_index]
              && (gen_mem[r.slot_index] == r.slot_generation);
        rsp = '0;
        rsp.status = ST_OK;
        rsp.handle_index = r.slot_index;
        rsp.handle_generation = r.slot_generation;
        case (r.operation)
            OP_CREATE: begin
                got = 1'b1;
                slot = '0;
                if (free_slots.size() > 0) begin
                    slot = free_slots[$];
                    free_slots.delete(free_slots.size() - 1);
                end else if (hw_mark < SLOTS) begin
                    slot = hw_mark[IDX_W-1:0];
                    hw_mark++;
                end else begin
                    got = 1'b0;
                end
                if (got) begin
                    live_bit[slot] = 1'b1;
                    live_cnt++;
                    rsp.handle_index = slot;
                    rsp.handle_generation = gen_mem[slot];
                end else begin
                    rsp.status = ST_FULL;
                end
            end
            OP_DESTROY: begin
                if (hit) begin
                    rsp.alive = 1'b1;
                    live_bit[r.slot_index] = 1'b0;
                    gen_mem[r.slot_index] = gen_mem[r.slot_index] + 1'b1;
                    free_slots.insert(free_slots.size(), r.slot_index);
                    if (live_cnt > 0)
                        live_cnt--;
                end else begin
                    rsp.status = ST_NOT_ALIVE;
                end
            end
            default: begin
                // query, and the spare code which acts the same
                if (hit)
                    rsp.alive = 1'b1;
                else
                    rsp.status = ST_NOT_ALIVE;
            end
        endcase
        rsp.live_total = live_cnt;
        rsp.slots_touched = hw_mark;
        return rsp;
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_errors < PRINT_LIMIT)
            $display("[%0t] MISMATCH %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents the next request on the falling edge once the current
    // one has been taken. Bursts of random length alternate with random gaps;
    // an item marked hold waits until no result is outstanding.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || req_taken)) begin
            if (pending.size() == 0 || gap_left > 0
                || (pending[0].hold && expected_rsp.size() != 0)) begin
                start <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end else begin
                drive_item = pending.pop_front();
                start <= 1'b1;
                i_req <= drive_item.req;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    // a quarter of bursts run straight into the next one
                    gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on each accepted request, checks each strobed result
    // and runs the watchdog. The block cannot be stalled on its result side.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_rsp want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            idle_cycles = 0;
        end else begin
            req_taken <= start && !busy;
            if (start && !busy)
                expected_rsp.insert(expected_rsp.size(), predict_step(i_req));
            if (o_done) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch("result transaction with no request outstanding");
                end else begin
                    want = expected_rsp.pop_front();
                    check_field("status", 64'(o_rsp.status), 64'(want.status));
                    check_field("handle_index", 64'(o_rsp.handle_index),
                                64'(want.handle_index));
                    check_field("handle_generation", 64'(o_rsp.handle_generation),
                                64'(want.handle_generation));
                    check_field("alive", 64'(o_rsp.alive), 64'(want.alive));
                    check_field("live_total", 64'(o_rsp.live_total),
                                64'(want.live_total));
                    check_field("slots_touched", 64'(o_rsp.slots_touched),
                                64'(want.slots_touched));
                end
            end
            if ((start && !busy) || o_done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog expired, pending %0d, outstanding %0d",
                         $realtime, pending.size(), expected_rsp.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic push_req(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [GEN_W-1:0] gen, input bit hold);
        t_stim s;
        s.req.operation = op;
        s.req.slot_index = idx;
        s.req.slot_generation = gen;
        s.hold = hold;
        pending.insert(pending.size(), s);
    endtask

    task automatic wait_pending_empty();
        while (pending.size() != 0)
            @(posedge i_clk);
    endtask

    // no request queued or in flight and every result back
    task automatic wait_quiet();
        while (pending.size() != 0 || start || expected_rsp.size() != 0)
            @(posedge i_clk);
    endtask

    // Mixed traffic built from the model's current state: creates and well-formed
    // handles of live slots, plus stale, mismatched, never-used and junk ones.
    task automatic plan_mixed(input int n, input bit hold);
        int unsigned      live_idx [$];
        int unsigned      top;
        int               roll;
        logic [IDX_W-1:0] ix;
        logic [1:0]       op;
        logic [GEN_W-1:0] gen;
        top = 32'(hw_mark);
        for (int i = 0; i < top; i++)
            if (live_bit[i])
                live_idx.insert(live_idx.size(), i);
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            op = OP_CREATE;
            ix = IDX_W'($urandom);
            gen = $urandom;
            if (roll < 35) begin
                // create; index and generation fields are don't-care
            end else if (roll < 75 && live_idx.size() > 0) begin
                ix = IDX_W'(live_idx[$urandom_range(live_idx.size() - 1)]);
                op = (roll < 60) ? OP_DESTROY : OP_QUERY;
                gen = gen_mem[ix];
            end else if (roll < 88 && top > 0) begin
                ix = IDX_W'($urandom_range(top - 1));
                op = $urandom_range(1) ? OP_DESTROY : OP_QUERY;
                if (roll < 83)
                    gen = gen_mem[ix] ^ (32'd1 << $urandom_range(GEN_W - 1));
                else
                    gen = gen_mem[ix] - GEN_W'($urandom_range(1));  // current or stale
            end else if (roll < 93 && top < SLOTS) begin
                // index beyond the high-water mark
                ix = IDX_W'($urandom_range(SLOTS - 1, top));
                op = $urandom_range(1) ? OP_DESTROY : OP_QUERY;
                if ($urandom_range(1))
                    gen = '0;
            end else if (roll < 97) begin
                op = OP_SPARE;
                if (live_idx.size() > 0 && $urandom_range(1)) begin
                    ix = IDX_W'(live_idx[$urandom_range(live_idx.size() - 1)]);
                    gen = gen_mem[ix];
                end
            end else begin
                op = 2'($urandom_range(3));
            end
            push_req(op, ix, gen, hold && (k == 0));
        end
    endtask

    initial begin : stimulus
        int unsigned      live_idx [$];
        int unsigned      tmp;
        int               j;
        logic [IDX_W-1:0] ix;
        for (int i = 0; i < SLOTS; i++) begin
            gen_mem[i] = '0;
            live_bit[i] = 1'b0;
        end
        hw_mark = '0;
        live_cnt = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, field extremes, reuse order, stale handles
        push_req(OP_QUERY,   10'd0,    32'd0,          1'b0);  // never used
        push_req(OP_DESTROY, 10'd1023, 32'hFFFF_FFFF,  1'b0);  // never used, extremes
        push_req(OP_CREATE,  10'd1023, 32'hFFFF_FFFF,  1'b0);  // slot 0
        push_req(OP_CREATE,  10'd0,    32'd0,          1'b0);  // slot 1
        push_req(OP_QUERY,   10'd0,    32'd0,          1'b0);  // live
        push_req(OP_QUERY,   10'd0,    32'h8000_0000,  1'b0);  // generation mismatch
        push_req(OP_SPARE,   10'd0,    32'd0,          1'b0);  // acts as query
        push_req(OP_DESTROY, 10'd0,    32'd0,          1'b0);  // slot 0 to generation 1
        push_req(OP_QUERY,   10'd0,    32'd0,          1'b0);  // stale
        push_req(OP_DESTROY, 10'd0,    32'd0,          1'b0);  // stale destroy
        push_req(OP_DESTROY, 10'd0,    32'd1,          1'b0);  // dead slot, current gen
        push_req(OP_CREATE,  10'd0,    32'd0,          1'b0);  // slot 0 off the stack
        push_req(OP_DESTROY, 10'd1,    32'd0,          1'b0);
        push_req(OP_DESTROY, 10'd0,    32'd1,          1'b0);
        push_req(OP_CREATE,  10'd0,    32'd0,          1'b0);  // last freed first: slot 0
        push_req(OP_CREATE,  10'd0,    32'd0,          1'b0);  // then slot 1
        push_req(OP_CREATE,  10'd0,    32'd0,          1'b0);  // fresh slot 2
        push_req(OP_QUERY,   10'd2,    32'hFFFF_FFFF,  1'b0);
        push_req(OP_QUERY,   10'd5,    32'd0,          1'b0);  // beyond high-water
        push_req(OP_SPARE,   10'd1023, 32'd0,          1'b0);
        push_req(OP_DESTROY, 10'd2,    32'd0,          1'b1);  // sent once all is back

        // first random stretch, store partly used
        for (int b = 0; b < 12; b++) begin
            wait_pending_empty();
            plan_mixed($urandom_range(15, 35), ($urandom_range(3) == 0));
        end

        // release a random subset of the live slots so the free stack runs deep
        wait_quiet();
        for (int i = 0; i < SLOTS; i++)
            if (live_bit[i])
                live_idx.insert(live_idx.size(), i);
        for (int k = 0; k < 300 && k < live_idx.size(); k++) begin
            j = $urandom_range(live_idx.size() - 1, k);
            tmp = live_idx[k];
            live_idx[k] = live_idx[j];
            live_idx[j] = tmp;
            ix = IDX_W'(live_idx[k]);
            push_req(OP_DESTROY, ix, gen_mem[ix], 1'b0);
            if ($urandom_range(4) == 0)
                push_req(OP_QUERY, ix, gen_mem[ix], 1'b0);
            if ($urandom_range(19) == 0)
                push_req(OP_DESTROY, ix, gen_mem[ix], 1'b0);
        end

        // second random stretch, reuse from the stack
        for (int b = 0; b < 12; b++) begin
            wait_pending_empty();
            plan_mixed($urandom_range(15, 35), ($urandom_range(3) == 0));
        end

        wait_quiet();
        // wait past the longest result path to catch a stray strobe
        repeat (8) @(posedge i_clk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
